// ----- rtl/kcs_pkg.sv -----
`timescale 1ns / 1ps

package kcs_pkg;

    // Default coordinate width: Q11.12 two's complement.
    localparam int COORD_WIDTH_DEF = 24;

    // Depth of the segment queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Quotient bits produced per cycle by the divide-by-three recurrence.
    localparam int DIV_DIGIT = 8;

    // Rotation by +60 degrees: cos = 2^14 / 2^15, sin = 28378 / 2^15.
    localparam int ROT_BITS = 15;
    localparam int ROT_COS_SHIFT = 14;
    localparam logic signed [15:0] ROT_SIN = 16'sd28378;

endpackage

// ----- rtl/kcs_fifo.sv -----
`timescale 1ns / 1ps

module kcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kcs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage for the waiting words.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count, wrapping at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/kcs_front.sv -----
`timescale 1ns / 1ps

module kcs_front #(
    parameter int COORD_WIDTH = kcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_start_flag,
    output logic                          o_q_push,
    input  logic                          i_q_full,
    output logic [6*COORD_WIDTH:0]        o_q_data
);

    localparam int W          = COORD_WIDTH;
    localparam int DG         = kcs_pkg::DIV_DIGIT;
    // The biased dividend needs W+3 bits; it is padded to whole digits.
    localparam int DIV_CYCLES = (W + 3 + DG - 1) / DG;
    localparam int LP         = DIV_CYCLES * DG;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    // Adding 3 * 2^(W+1) makes the dividend non-negative, so that an
    // unsigned quotient less 2^(W+1) is the floored signed quotient.
    localparam logic [LP-1:0] DIV_BIAS = LP'(3) << (W + 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state          r_state;
    t_front_state          n_state;
    logic signed [W-1:0]   r_prev_x;
    logic signed [W-1:0]   r_prev_y;
    logic                  r_have_prev;
    logic signed [W-1:0]   r_p1_x;
    logic signed [W-1:0]   r_p1_y;
    logic signed [W-1:0]   r_p2_x;
    logic signed [W-1:0]   r_p2_y;
    logic                  r_pass;
    logic [LP-1:0]         r_num_x;
    logic [LP-1:0]         r_num_y;
    logic [LP-1:0]         r_quo_x;
    logic [LP-1:0]         r_quo_y;
    logic [1:0]            r_rem_x;
    logic [1:0]            r_rem_y;
    logic [CNT_W-1:0]      r_cnt;
    logic                  w_accept;
    logic [DG+1:0]         w_dig_x;
    logic [DG+1:0]         w_dig_y;

    // One digit of long division by three: remainder stays in 0..2.
    function automatic logic [DG+1:0] div3_digit(input logic [1:0]    rem,
                                                 input logic [DG-1:0] bits);
        logic [2:0]    t;
        logic [1:0]    r;
        logic [DG-1:0] q;
        r = rem;
        q = '0;
        for (int i = DG - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= 3'd3) begin
                q[i] = 1'b1;
                r    = 2'(t - 3'd3);
            end else begin
                r = t[1:0];
            end
        end
        return {r, q};
    endfunction

    assign o_full   = (r_state != F_IDLE);
    assign w_accept = i_push && (r_state == F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign w_dig_x  = div3_digit(r_rem_x, r_num_x[LP-1 -: DG]);
    assign w_dig_y  = div3_digit(r_rem_y, r_num_y[LP-1 -: DG]);

    // The low W quotient bits are d itself, since the bias sits above them.
    assign o_q_data = {r_pass, r_p1_x, r_p1_y, r_quo_x[W-1:0], r_quo_y[W-1:0],
                       r_p2_x, r_p2_y};

    // Sequencer: accept, divide the difference by three unless the word passes straight through, hand the word on.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = (i_start_flag || !r_have_prev) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Control state and the kept vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_have_prev <= 1'b1;
                r_prev_x    <= i_point_x;
                r_prev_y    <= i_point_y;
            end
        end
    end

    // Segment payload and the divide-by-three recurrence.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pass  <= i_start_flag || !r_have_prev;
            r_p1_x  <= r_prev_x;
            r_p1_y  <= r_prev_y;
            r_p2_x  <= i_point_x;
            r_p2_y  <= i_point_y;
            r_num_x <= LP'(i_point_x) - LP'(r_prev_x) + LP'(1) + DIV_BIAS;
            r_num_y <= LP'(i_point_y) - LP'(r_prev_y) + LP'(1) + DIV_BIAS;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_cnt   <= '0;
        end else if (r_state == F_DIV) begin
            r_num_x <= r_num_x << DG;
            r_num_y <= r_num_y << DG;
            r_quo_x <= {r_quo_x[LP-DG-1:0], w_dig_x[DG-1:0]};
            r_quo_y <= {r_quo_y[LP-DG-1:0], w_dig_y[DG-1:0]};
            r_rem_x <= w_dig_x[DG+1:DG];
            r_rem_y <= w_dig_y[DG+1:DG];
            r_cnt   <= r_cnt + 1'b1;
        end
    end

endmodule

// ----- rtl/kcs_back.sv -----
`timescale 1ns / 1ps

module kcs_back #(
    parameter int COORD_WIDTH = kcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic [6*COORD_WIDTH:0]        i_q_data,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_last_of_run
);

    localparam int W  = COORD_WIDTH;
    localparam int MW = W + 16;
    localparam int NW = W + 17;
    localparam logic signed [NW-1:0] ROUND = NW'(1) <<< (kcs_pkg::ROT_BITS - 1);
    localparam logic [1:0] K_FIRST = 2'd0;
    localparam logic [1:0] K_PEAK  = 2'd1;
    localparam logic [1:0] K_THIRD = 2'd2;
    localparam logic [1:0] K_LAST  = 2'd3;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_SUM  = 4'b0100,
        B_EMIT = 4'b1000
    } t_back_state;

    t_back_state          r_state;
    t_back_state          n_state;
    logic signed [W-1:0]  r_p1_x;
    logic signed [W-1:0]  r_p1_y;
    logic signed [W-1:0]  r_d_x;
    logic signed [W-1:0]  r_d_y;
    logic signed [W-1:0]  r_p2_x;
    logic signed [W-1:0]  r_p2_y;
    logic signed [MW-1:0] r_ms_x;
    logic signed [MW-1:0] r_ms_y;
    logic signed [W+1:0]  r_s_x;
    logic signed [W+1:0]  r_s_y;
    logic [1:0]           r_k;
    logic                 r_out_valid;
    logic                 w_pass;
    logic signed [W-1:0]  w_p1_x;
    logic signed [W-1:0]  w_p1_y;
    logic signed [W-1:0]  w_d_x;
    logic signed [W-1:0]  w_d_y;
    logic signed [W-1:0]  w_p2_x;
    logic signed [W-1:0]  w_p2_y;
    logic signed [NW-1:0] w_rx_num;
    logic signed [NW-1:0] w_ry_num;
    logic signed [W+1:0]  w_sel_x;
    logic signed [W+1:0]  w_sel_y;
    logic signed [W+2:0]  w_sum_x;
    logic signed [W+2:0]  w_sum_y;
    logic                 w_load;

    // Clamp to the signed W-bit range when the top bits disagree.
    function automatic logic [W-1:0] sat(input logic signed [W+2:0] v);
        if (v[W+2:W-1] == {4{v[W+2]}}) begin
            return v[W-1:0];
        end else if (v[W+2]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    assign {w_pass, w_p1_x, w_p1_y, w_d_x, w_d_y, w_p2_x, w_p2_y} = i_q_data;

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty = !r_out_valid;
    assign w_load  = (r_state == B_EMIT) && (!r_out_valid || i_pop);

    // Rotation numerators: cos term is a shift, sin term comes registered.
    assign w_rx_num = (NW'(r_d_x) <<< kcs_pkg::ROT_COS_SHIFT) - NW'(r_ms_y) + ROUND;
    assign w_ry_num = (NW'(r_d_y) <<< kcs_pkg::ROT_COS_SHIFT) + NW'(r_ms_x) + ROUND;

    // Offset from P1 for the result in hand: d, d + r or 2d.
    always_comb begin
        unique case (r_k)
            K_FIRST: begin
                w_sel_x = (W+2)'(r_d_x);
                w_sel_y = (W+2)'(r_d_y);
            end
            K_PEAK: begin
                w_sel_x = r_s_x;
                w_sel_y = r_s_y;
            end
            K_THIRD, K_LAST: begin
                w_sel_x = (W+2)'(r_d_x) <<< 1;
                w_sel_y = (W+2)'(r_d_y) <<< 1;
            end
            default: begin
                w_sel_x = '0;
                w_sel_y = '0;
            end
        endcase
    end

    assign w_sum_x = (W+3)'(r_p1_x) + (W+3)'(w_sel_x);
    assign w_sum_y = (W+3)'(r_p1_y) + (W+3)'(w_sel_y);

    // Sequencer: take a word, rotate unless it passes straight through, then hand out the results in order.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = w_pass ? B_EMIT : B_MUL;
                end
            end
            B_MUL:  n_state = B_SUM;
            B_SUM:  n_state = B_EMIT;
            B_EMIT: begin
                if (w_load && (r_k == K_LAST)) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control state and the output word's valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Segment payload, rotation products and the output register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_p1_x <= w_p1_x;
            r_p1_y <= w_p1_y;
            r_d_x  <= w_d_x;
            r_d_y  <= w_d_y;
            r_p2_x <= w_p2_x;
            r_p2_y <= w_p2_y;
            r_k    <= w_pass ? K_LAST : K_FIRST;
        end
        if (r_state == B_MUL) begin
            r_ms_x <= MW'(r_d_x) * MW'(kcs_pkg::ROT_SIN);
            r_ms_y <= MW'(r_d_y) * MW'(kcs_pkg::ROT_SIN);
        end
        if (r_state == B_SUM) begin
            r_s_x <= (W+2)'(r_d_x) + (W+2)'(w_rx_num >>> kcs_pkg::ROT_BITS);
            r_s_y <= (W+2)'(r_d_y) + (W+2)'(w_ry_num >>> kcs_pkg::ROT_BITS);
        end
        if (w_load) begin
            r_k           <= r_k + 1'b1;
            o_last_of_run <= (r_k == K_LAST);
            if (r_k == K_LAST) begin
                o_out_x <= r_p2_x;
                o_out_y <= r_p2_y;
            end else begin
                o_out_x <= sat(w_sum_x);
                o_out_y <= sat(w_sum_y);
            end
        end
    end

endmodule

// ----- rtl/koch_curve_subdivision.sv -----
// Koch curve subdivision of a polyline.
// Input queue: vertices enter on i_point_x, i_point_y (signed fixed point)
// with i_start_flag; a word is taken when push is high and full is low.
// Output queue: while empty is low the oldest result waits on o_out_x,
// o_out_y and o_last_of_run; it is taken when pop is high.
// A start vertex, or any vertex before one has been kept, gives one result.
// Every later vertex gives four: one third, the peak, two thirds and the
// vertex itself, the last of them marked by o_last_of_run.
// A start vertex passes through the front, the queue and the output
// register; a segment vertex also goes through the division, the multiply
// and the sum before its first result is registered.
// The front takes no new vertex until it has handed its word to the queue,
// its divide-by-three recurrence running 8 bits a cycle; the back takes a
// start vertex and emits one result, or takes a segment word, multiplies,
// sums and emits four results, each emit waiting while the receiver stalls.
// A two-word queue lets the front take the next vertex while the back works.
// Reset clears the kept vertex and empties both sides. A stalled receiver
// holds the output word; the back, then the queue, then full back up.
`timescale 1ns / 1ps

module koch_curve_subdivision #(
    parameter int COORD_WIDTH = kcs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_start_flag,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_last_of_run
);

    localparam int ENTRY_W = 6 * COORD_WIDTH + 1;

    logic               w_fq_push;
    logic               w_fq_full;
    logic [ENTRY_W-1:0] w_fq_data;
    logic               w_qb_pop;
    logic               w_qb_empty;
    logic [ENTRY_W-1:0] w_qb_data;

    // Front: takes vertices, keeps the previous one, forms d.
    kcs_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_start_flag(i_start_flag),
        .o_q_push    (w_fq_push),
        .i_q_full    (w_fq_full),
        .o_q_data    (w_fq_data)
    );

    // Segment queue between the two halves.
    kcs_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(kcs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fq_push),
        .o_full (w_fq_full),
        .i_data (w_fq_data),
        .i_pop  (w_qb_pop),
        .o_empty(w_qb_empty),
        .o_data (w_qb_data)
    );

    // Back: rotation, saturating sums and the output register.
    kcs_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_qb_empty),
        .o_q_pop      (w_qb_pop),
        .i_q_data     (w_qb_data),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_of_run(o_last_of_run)
    );

endmodule

// ----- test/koch_curve_subdivision_tb.sv -----
`timescale 1ns / 1ps

module koch_curve_subdivision_tb;

    localparam int W = kcs_pkg::COORD_WIDTH_DEF;
    localparam int FRAC = 12;
    localparam longint ONE = longint'(1) <<< FRAC;
    localparam longint COORD_MAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint ROT_C = longint'(1) <<< kcs_pkg::ROT_COS_SHIFT;
    localparam longint ROT_S = longint'(kcs_pkg::ROT_SIN);

    typedef struct {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic                last;
    } t_vertex_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic signed [W-1:0] i_point_x = '0;
    logic signed [W-1:0] i_point_y = '0;
    logic                i_start_flag = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic signed [W-1:0] o_out_x;
    logic signed [W-1:0] o_out_y;
    logic                o_last_of_run;

    // Expected output words, oldest first, and the vertex the predictor keeps.
    t_vertex_word expected_words[$];
    longint       kept_x = 0;
    longint       kept_y = 0;
    bit           kept_valid = 1'b0;

    bit idle_on = 1'b1;
    int rx_stall_left = 0;
    int rx_hold_cycles = 0;
    int mismatches = 0;
    int words_checked = 0;
    int vertices_sent = 0;
    int full_stall_cycles = 0;

    koch_curve_subdivision #(
        .COORD_WIDTH(W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_start_flag (i_start_flag),
        .empty        (empty),
        .pop          (pop),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_of_run(o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Clamps an exact sum to the signed coordinate range.
    function automatic longint saturate_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Division by three rounded towards minus infinity.
    function automatic longint floor_third(longint n);
        longint q;
        q = n / 3;
        if (n % 3 < 0) q = q - 1;
        return q;
    endfunction

    function automatic void queue_word(longint x, longint y, bit last);
        t_vertex_word w;
        w.x = W'(saturate_coord(x));
        w.y = W'(saturate_coord(y));
        w.last = last;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Works out the words one vertex causes and moves the kept vertex on.
    function automatic void subdivide_vertex(longint px, longint py, logic first);
        longint dx, dy, rx, ry;
        if (first || !kept_valid) begin
            queue_word(px, py, 1'b1);
        end else begin
            // One third of the segment, rounded to nearest, then turned by +60 degrees.
            dx = floor_third(px - kept_x + 1);
            dy = floor_third(py - kept_y + 1);
            rx = (dx * ROT_C - dy * ROT_S + (longint'(1) <<< (kcs_pkg::ROT_BITS - 1)))
                 >>> kcs_pkg::ROT_BITS;
            ry = (dy * ROT_C + dx * ROT_S + (longint'(1) <<< (kcs_pkg::ROT_BITS - 1)))
                 >>> kcs_pkg::ROT_BITS;
            queue_word(kept_x + dx, kept_y + dy, 1'b0);
            queue_word(kept_x + dx + rx, kept_y + dy + ry, 1'b0);
            queue_word(kept_x + 2 * dx, kept_y + 2 * dy, 1'b0);
            queue_word(px, py, 1'b1);
        end
        kept_x = px;
        kept_y = py;
        kept_valid = 1'b1;
    endfunction

    // Mostly full-range or near the kept vertex, sometimes at the extremes.
    function automatic longint random_coord(longint near);
        longint v;
        int span;
        span = 1 << $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = longint'($urandom % (1 << W)) + COORD_MIN;
            8: v = COORD_MAX;
            9: v = COORD_MIN;
            default: v = near + longint'($urandom_range(0, 2 * span)) - span;
        endcase
        return saturate_coord(v);
    endfunction

    // Offers one vertex and returns at the edge that takes it; push stays high.
    task automatic send_vertex(input longint x, input longint y, input logic first);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_point_x <= W'(x);
        i_point_y <= W'(y);
        i_start_flag <= first;
        @(negedge i_clk);
        while (full) begin
            full_stall_cycles++;
            @(negedge i_clk);
        end
        subdivide_vertex(x, y, first);
        vertices_sent++;
        @(posedge i_clk);
    endtask

    // Stops offering and waits until every expected word has been taken.
    task automatic wait_for_drain();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic test_directed();
        send_vertex(5 * ONE, -7 * ONE, 1'b0);   // continuation with nothing kept
        send_vertex(0, 0, 1'b1);
        send_vertex(3 * ONE, 0, 1'b0);
        send_vertex(3 * ONE, 0, 1'b0);           // degenerate segment
        send_vertex(-ONE, 2 * ONE, 1'b1);
        send_vertex(4 * ONE, 4 * ONE, 1'b1);     // repeated start
        send_vertex(4 * ONE + 1, 4 * ONE - 1, 1'b0);
        send_vertex(4 * ONE + 3, 4 * ONE, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        // Peaks that saturate in each direction.
        send_vertex(0, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, 0, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, 0, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(-1, -1, 1'b0);
        send_vertex(0, 0, 1'b0);
    endtask

    // Polylines of random length; now and then a stray start or a missing one.
    task automatic test_random_polylines(input int n_items);
        int left;
        int seg_len;
        logic first;
        longint x, y;
        left = n_items;
        while (left > 0) begin
            seg_len = $urandom_range(1, 12);
            for (int k = 0; k < seg_len && left > 0; k++) begin
                if (k == 0) first = ($urandom_range(0, 19) != 0);
                else first = ($urandom_range(0, 24) == 0);
                x = random_coord(kept_x);
                y = random_coord(kept_y);
                send_vertex(x, y, first);
                left--;
            end
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_full_backpressure();
        wait_for_drain();
        @(negedge i_clk);
        rx_hold_cycles = 200;
        @(posedge i_clk);
        test_random_polylines(24);
    endtask

    // No idling on either side for the closing stretch.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_polylines(60);
    endtask

    // Receiver: random stall bursts, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            pop <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else if (rx_stall_left > 0) begin
            pop <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            rx_stall_left = $urandom_range(0, 5);
        end else begin
            pop <= 1'b1;
        end
    end

    // Each word taken at the coming edge is compared with the oldest expectation.
    always @(negedge i_clk) begin : check_words
        t_vertex_word want;
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word x=%0d y=%0d last=%0b",
                             o_out_x, o_out_y, o_last_of_run);
            end else begin
                want = expected_words.pop_front();
                if (o_out_x !== want.x || o_out_y !== want.y || o_last_of_run !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 words_checked, want.x, want.y, want.last,
                                 o_out_x, o_out_y, o_last_of_run);
                end
                words_checked++;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_polylines(150);
        wait_for_drain();
        test_random_polylines(150);
        test_full_backpressure();
        test_back_to_back();

        // Let the block settle so that any stray word shows up.
        wait_for_drain();
        repeat (40) @(posedge i_clk);

        if (expected_words.size() != 0) begin
            mismatches++;
            $display("%0d expected words never arrived", expected_words.size());
        end
        $display("Sent %0d vertices (polylines, stray and missing starts, saturating peaks),",
                 vertices_sent);
        $display("checked %0d words; the input was held off by a full block for %0d cycles.",
                 words_checked, full_stall_cycles);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("timed out with %0d words outstanding", expected_words.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kcs_pkg.sv
rtl/kcs_fifo.sv
rtl/kcs_front.sv
rtl/kcs_back.sv
rtl/koch_curve_subdivision.sv
test/koch_curve_subdivision_tb.sv
